// ===== rtl/sfba_pkg.sv =====
// Shared types, sizes and codes of the segregated-fit block allocator.
package sfba_pkg;

    localparam int BUCKET_COUNT = 29;
    localparam int PAGE_BYTES   = 4096;
    localparam int MAX_PAGES    = 128;

    localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
    localparam int STORE_DEPTH  = MAX_PAGES * PAGE_BYTES / 8;
    localparam int SLOT_W       = $clog2(STORE_DEPTH);
    localparam int LINK_W       = SLOT_W + 1;
    localparam int BKT_W        = $clog2(BUCKET_COUNT);
    localparam int ENTRY_W      = 20;
    localparam int MARK_BIT     = ENTRY_W - 1;
    localparam int OFF_W        = $clog2(MAX_PAGES * PAGE_BYTES) + 1;
    localparam int NPG_W        = $clog2(MAX_PAGES + 1);
    localparam int CNT_W        = $clog2(PAGE_BYTES / 8 + 1);

    localparam logic [0:0] CMD_ALLOC = 1'b0;
    localparam logic [0:0] CMD_FREE  = 1'b1;

    localparam logic [0:0] CFG_PAGE_COUNT  = 1'b0;
    localparam logic [0:0] CFG_REGION_BASE = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_ZERO     = 3'd1,
        STAT_LARGE    = 3'd2,
        STAT_OOM      = 3'd3,
        STAT_BADFREE  = 3'd4,
        STAT_NULLFREE = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SIZE,
        ST_HEAD,
        ST_REFILL,
        ST_CARVE,
        ST_POP_RD,
        ST_POP_WR,
        ST_FCHK,
        ST_FTAG,
        ST_FPUSH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               we;
        logic [SLOT_W-1:0]  addr;
        logic [ENTRY_W-1:0] wdata;
    } hdr_req_t;

endpackage

// ===== rtl/sfba_hdr_ram.sv =====
// Single-port block header store with a registered read.
module sfba_hdr_ram (
    input  logic                      aclk,
    input  sfba_pkg::hdr_req_t        req,
    output logic [sfba_pkg::ENTRY_W-1:0] rdata
);
    import sfba_pkg::*;

    logic [ENTRY_W-1:0] mem [STORE_DEPTH];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.addr] <= req.wdata;
        end
        rdata <= mem[req.addr];
    end

endmodule

// ===== rtl/segregated_fit_block_allocator.sv =====
// Top level of the segregated-fit block allocator: sequencer, bucket heads and outputs.
//
// Usage. Requests arrive on the s_ channel (valid/ready): s_command selects
// allocate or free, s_request_size is the user size for an allocate and
// s_block_address the user pointer for a free. Each request yields exactly
// one result on the m_ channel: m_granted_address and m_status.
// Configuration (page_count, region_base) is written through cfg_we,
// cfg_index and cfg_data while no request is in flight.
//
// Timing. One request is worked at a time and s_ready is high only in idle.
// For a free, a null, out-of-region or misaligned pointer is turned away after
// the address check, a bad tag after the header read. An allocate walks the
// bucket sizes with one shared shift/compare step per cycle, then pops the
// free list. When the bucket is empty, the refill carves a page (or, for a
// block larger than a page, one block of whole pages) with one header-store
// write per cycle. The single header-store port sets that rate.
//
// Reset clears the bucket lists and the page counter, then a clearing pass
// writes zero to all STORE_DEPTH header entries before the first request is
// taken. A stalled receiver holds the result in the output register; the
// block finishes its current request and then waits.
module segregated_fit_block_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [0:0]  s_command,
    input  logic [31:0] s_request_size,
    input  logic [31:0] s_block_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_granted_address,
    output logic [2:0]  m_status
);
    import sfba_pkg::*;

    state_t state_reg, state_next;

    logic [7:0]        page_count_reg;
    logic [31:0]       region_base_reg;
    logic [LINK_W-1:0] head_reg [BUCKET_COUNT];
    logic [NPG_W-1:0]  next_page_reg, next_page_next;
    logic [SLOT_W-1:0] clr_reg;

    logic [0:0]        cmd_reg;
    logic [31:0]       ptr_reg;
    logic [32:0]       need_reg, need_next;
    logic [32:0]       bsize_reg, bsize_next;
    logic [BKT_W-1:0]  idx_reg, idx_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [31:0]       addr_reg, addr_next;
    status_t           stat_reg, stat_next;

    logic              m_valid_reg;
    logic [31:0]       m_addr_reg;
    status_t           m_stat_reg;

    logic              head_we;
    logic [LINK_W-1:0] head_wdata;
    hdr_req_t          ram_req;
    logic [ENTRY_W-1:0] ram_rdata;

    // Derived values used by the sequencer.
    logic [NPG_W-1:0]  usable;
    logic [LINK_W-1:0] head_cur;
    logic [32:0]       need_in;
    logic [33:0]       new_next;
    logic              small_block;
    logic [31:0]       free_off;
    logic              free_bad;
    logic              out_free;

    sfba_hdr_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    assign usable = (page_count_reg > 8'(MAX_PAGES)) ? NPG_W'(MAX_PAGES)
                                                      : NPG_W'(page_count_reg);
    assign head_cur    = head_reg[idx_reg];
    assign need_in     = {1'b0, s_request_size} + 33'd4;
    assign small_block = (bsize_reg <= 33'(PAGE_BYTES));
    // A block larger than a page spans bsize/PAGE_BYTES whole pages.
    assign new_next    = 34'(next_page_reg) +
                         (small_block ? 34'd1 : 34'(bsize_reg >> PAGE_SHIFT));
    assign free_off    = ptr_reg - 32'd4 - region_base_reg;
    assign free_bad    = (free_off >= (32'(usable) << PAGE_SHIFT)) || (free_off[2:0] != 3'd0);
    assign out_free    = !m_valid_reg || m_ready;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == SLOT_W'(STORE_DEPTH - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_command == CMD_FREE) state_next = ST_FCHK;
                    else if (s_request_size == 32'd0 || need_in[32]) state_next = ST_DONE;
                    else state_next = ST_SIZE;
                end
            end
            ST_SIZE: begin
                if (bsize_reg >= need_reg) state_next = ST_HEAD;
                else if (idx_reg == BKT_W'(BUCKET_COUNT - 1)) state_next = ST_DONE;
            end
            ST_HEAD:   state_next = (head_cur != '0) ? ST_POP_RD : ST_REFILL;
            ST_REFILL: state_next = (new_next >= 34'(usable)) ? ST_DONE : ST_CARVE;
            ST_CARVE: begin
                if (cnt_reg == CNT_W'(1)) state_next = ST_POP_RD;
            end
            ST_POP_RD: state_next = ST_POP_WR;
            ST_POP_WR: state_next = ST_DONE;
            ST_FCHK: begin
                if (ptr_reg == 32'd0 || free_bad) state_next = ST_DONE;
                else state_next = ST_FTAG;
            end
            ST_FTAG: begin
                if (!ram_rdata[MARK_BIT] || ram_rdata[BKT_W-1:0] >= BKT_W'(BUCKET_COUNT))
                    state_next = ST_DONE;
                else state_next = ST_FPUSH;
            end
            ST_FPUSH:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and output logic.
    always_comb begin
        need_next      = need_reg;
        bsize_next     = bsize_reg;
        idx_next       = idx_reg;
        off_next       = off_reg;
        cnt_next       = cnt_reg;
        slot_next      = slot_reg;
        addr_next      = addr_reg;
        stat_next      = stat_reg;
        next_page_next = next_page_reg;
        head_we        = 1'b0;
        head_wdata     = '0;
        ram_req.we     = 1'b0;
        ram_req.addr   = slot_reg;
        ram_req.wdata  = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_req.we   = 1'b1;
                ram_req.addr = clr_reg;
            end
            ST_IDLE: begin
                need_next  = need_in;
                bsize_next = 33'd8;
                idx_next   = '0;
                addr_next  = '0;
                stat_next  = STAT_OK;
                // The size checks only apply to an allocate.
                if (s_command == CMD_ALLOC) begin
                    if (s_request_size == 32'd0) stat_next = STAT_ZERO;
                    else if (need_in[32]) stat_next = STAT_LARGE;
                end
            end
            ST_SIZE: begin
                // One doubling of the candidate block size per cycle.
                if (bsize_reg < need_reg) begin
                    if (idx_reg == BKT_W'(BUCKET_COUNT - 1)) stat_next = STAT_LARGE;
                    else begin
                        idx_next   = idx_reg + BKT_W'(1);
                        bsize_next = bsize_reg << 1;
                    end
                end
            end
            ST_HEAD: ;
            ST_REFILL: begin
                if (new_next >= 34'(usable)) begin
                    next_page_next = usable;
                    stat_next      = STAT_OOM;
                end else begin
                    next_page_next = NPG_W'(new_next);
                    off_next       = OFF_W'(next_page_reg) << PAGE_SHIFT;
                    cnt_next       = small_block ? CNT_W'((PAGE_BYTES / 8) >> idx_reg)
                                                 : CNT_W'(1);
                end
            end
            ST_CARVE: begin
                // Push blocks in address order; the last one becomes the head.
                ram_req.we    = 1'b1;
                ram_req.addr  = off_reg[SLOT_W+2:3];
                ram_req.wdata = ENTRY_W'(head_cur);
                head_we       = 1'b1;
                head_wdata    = LINK_W'(off_reg[SLOT_W+2:3]) + LINK_W'(1);
                off_next      = off_reg + OFF_W'(bsize_reg);
                cnt_next      = cnt_reg - CNT_W'(1);
            end
            ST_POP_RD: begin
                slot_next    = SLOT_W'(head_cur - LINK_W'(1));
                ram_req.addr = SLOT_W'(head_cur - LINK_W'(1));
            end
            ST_POP_WR: begin
                head_we       = 1'b1;
                head_wdata    = ram_rdata[LINK_W-1:0];
                ram_req.we    = 1'b1;
                ram_req.wdata = {1'b1, (ENTRY_W-1-BKT_W)'(0), idx_reg};
                addr_next     = region_base_reg + {13'(0), slot_reg, 3'b000} + 32'd4;
            end
            ST_FCHK: begin
                slot_next    = free_off[SLOT_W+2:3];
                ram_req.addr = free_off[SLOT_W+2:3];
                if (ptr_reg == 32'd0) stat_next = STAT_NULLFREE;
                else if (free_bad) stat_next = STAT_BADFREE;
            end
            ST_FTAG: begin
                idx_next = ram_rdata[BKT_W-1:0];
                if (!ram_rdata[MARK_BIT] || ram_rdata[BKT_W-1:0] >= BKT_W'(BUCKET_COUNT))
                    stat_next = STAT_BADFREE;
            end
            ST_FPUSH: begin
                ram_req.we    = 1'b1;
                ram_req.wdata = ENTRY_W'(head_cur);
                head_we       = 1'b1;
                head_wdata    = LINK_W'(slot_reg) + LINK_W'(1);
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            page_count_reg  <= 8'(MAX_PAGES);
            region_base_reg <= '0;
            next_page_reg   <= '0;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < BUCKET_COUNT; i++) head_reg[i] <= '0;
        end else begin
            state_reg     <= state_next;
            next_page_reg <= next_page_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + SLOT_W'(1);
            if (cfg_we) begin
                if (cfg_index == CFG_PAGE_COUNT) page_count_reg <= cfg_data[7:0];
                else region_base_reg <= cfg_data;
            end
            if (head_we) head_reg[idx_reg] <= head_wdata;
            if (state_reg == ST_DONE && out_free) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        need_reg  <= need_next;
        bsize_reg <= bsize_next;
        idx_reg   <= idx_next;
        off_reg   <= off_next;
        cnt_reg   <= cnt_next;
        slot_reg  <= slot_next;
        addr_reg  <= addr_next;
        stat_reg  <= stat_next;
        if (state_reg == ST_IDLE && s_valid) begin
            cmd_reg <= s_command;
            ptr_reg <= s_block_address;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_addr_reg <= (stat_reg == STAT_OK && cmd_reg == CMD_ALLOC) ? addr_reg : 32'd0;
            m_stat_reg <= stat_reg;
        end
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_granted_address = m_addr_reg;
    assign m_status          = m_stat_reg;

    // A failed result never carries an address; a free result carries none either.
    a_fail_no_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STAT_OK) |-> (m_granted_address == 32'd0))
        else $error("failed result carries an address");

    // A pop only happens from a non-empty list.
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP_RD) |-> (head_cur != '0))
        else $error("pop from an empty bucket");

    // The page counter never runs past the region size.
    a_page_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (next_page_reg <= NPG_W'(MAX_PAGES)))
        else $error("page counter out of range");

    // A carve always ends with the bucket refilled.
    a_carve_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CARVE && cnt_reg == CNT_W'(1)) |=> (head_cur != '0))
        else $error("refill left the bucket empty");

endmodule
